// ===== rtl/core/bearing_sector_target_search_macros.svh =====
// Assertion macros for the bearing sector target search block.
`ifndef BEARING_SECTOR_TARGET_SEARCH_MACROS_SVH
`define BEARING_SECTOR_TARGET_SEARCH_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define BSTS_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// Next-cycle implication checked on every clock edge outside reset.
`define BSTS_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

// ===== rtl/core/bsts_pkg.sv =====
// Package with types and constants for the bearing sector target search block.
`default_nettype none
package bsts_pkg;
   localparam int unsigned FULL_TURN    = 23040;
   localparam int unsigned CORDIC_STEPS = 18;
   localparam int unsigned SQRT_STEPS   = 16;

   localparam logic [0:0] REQ_WRITE = 1'b0;
   localparam logic [0:0] REQ_QUERY = 1'b1;

   localparam logic [0:0] CSR_ENTRY_COUNT = 1'b0;
   localparam logic [0:0] CSR_HALF_WINDOW = 1'b1;

   typedef struct packed {
      logic              req_type;
      logic [5:0]        entry_index;
      logic signed [15:0] pos_x;
      logic signed [15:0] pos_y;
      logic signed [15:0] pos_z;
      logic [14:0]       query_angle;
   } req_type_type;

   typedef struct packed {
      logic       match_found;
      logic [5:0] match_index;
   } rsp_type;

   typedef enum logic [3:0] {
      ST_IDLE, ST_READ, ST_LOAD, ST_SQUARE, ST_SQRT, ST_SETUP, ST_CORDIC,
      ST_COMPARE, ST_RESP
   } state_type;

   // Controller to datapath.
   typedef struct packed {
      logic take_item;
      logic write_entry;
      logic read_entry;
      logic load_entry;
      logic square;
      logic sqrt_step;
      logic cordic_setup;
      logic cordic_step;
      logic compare;
      logic next_entry;
      logic set_result;
   } cmd_type;

   // Datapath to controller.
   typedef struct packed {
      logic is_query;
      logic scan_done;
      logic entry_zero;
      logic wide_window;
      logic sqrt_last;
      logic cordic_last;
      logic hit;
   } status_type;

   function automatic logic [21:0] atan_entry(input logic [4:0] i);
      logic [21:0] v;
      case (i)
         5'd0: v = 22'd737280;
         5'd1: v = 22'd435242;
         5'd2: v = 22'd229970;
         5'd3: v = 22'd116736;
         5'd4: v = 22'd58595;
         5'd5: v = 22'd29326;
         5'd6: v = 22'd14667;
         5'd7: v = 22'd7334;
         5'd8: v = 22'd3667;
         5'd9: v = 22'd1833;
         5'd10: v = 22'd917;
         5'd11: v = 22'd458;
         5'd12: v = 22'd229;
         5'd13: v = 22'd115;
         5'd14: v = 22'd57;
         5'd15: v = 22'd29;
         5'd16: v = 22'd14;
         5'd17: v = 22'd7;
         default: v = 22'd0;
      endcase
      return v;
   endfunction
endpackage
`default_nettype wire

// ===== rtl/core/bsts_ctrl.sv =====
// Controller state machine for the bearing sector target search block.
`default_nettype none
module bsts_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output bsts_pkg::cmd_type           cmd,
   input  wire bsts_pkg::status_type   sts
);
   bsts_pkg::state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= bsts_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         bsts_pkg::ST_IDLE: begin
            if (req_valid) state_in = bsts_pkg::ST_READ;
         end
         bsts_pkg::ST_READ: begin
            if (!sts.is_query || sts.scan_done) state_in = bsts_pkg::ST_RESP;
            else state_in = bsts_pkg::ST_LOAD;
         end
         bsts_pkg::ST_LOAD: begin
            if (sts.entry_zero) state_in = bsts_pkg::ST_READ;
            else if (sts.wide_window) state_in = bsts_pkg::ST_RESP;
            else state_in = bsts_pkg::ST_SQUARE;
         end
         bsts_pkg::ST_SQUARE: state_in = bsts_pkg::ST_SQRT;
         bsts_pkg::ST_SQRT: begin
            if (sts.sqrt_last) state_in = bsts_pkg::ST_SETUP;
         end
         bsts_pkg::ST_SETUP: state_in = bsts_pkg::ST_CORDIC;
         bsts_pkg::ST_CORDIC: begin
            if (sts.cordic_last) state_in = bsts_pkg::ST_COMPARE;
         end
         bsts_pkg::ST_COMPARE: begin
            if (sts.hit) state_in = bsts_pkg::ST_RESP;
            else state_in = bsts_pkg::ST_READ;
         end
         bsts_pkg::ST_RESP: begin
            if (rsp_ready) state_in = bsts_pkg::ST_IDLE;
         end
         default: state_in = bsts_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         bsts_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            cmd.take_item = req_valid;
         end
         bsts_pkg::ST_READ: begin
            cmd.write_entry = !sts.is_query;
            cmd.read_entry = sts.is_query && !sts.scan_done;
         end
         bsts_pkg::ST_LOAD: begin
            cmd.load_entry = 1'b1;
            cmd.next_entry = sts.entry_zero;
            cmd.set_result = !sts.entry_zero && sts.wide_window;
         end
         bsts_pkg::ST_SQUARE: cmd.square = 1'b1;
         bsts_pkg::ST_SQRT: cmd.sqrt_step = 1'b1;
         bsts_pkg::ST_SETUP: cmd.cordic_setup = 1'b1;
         bsts_pkg::ST_CORDIC: cmd.cordic_step = 1'b1;
         bsts_pkg::ST_COMPARE: begin
            cmd.compare = 1'b1;
            cmd.set_result = sts.hit;
            cmd.next_entry = !sts.hit;
         end
         bsts_pkg::ST_RESP: rsp_valid = 1'b1;
         default: ;
      endcase
   end
endmodule
`default_nettype wire

// ===== rtl/core/bsts_datapath.sv =====
// Datapath: position memory, integer root, CORDIC bearing and window compare.
`default_nettype none
module bsts_datapath #(
   parameter int unsigned MAX_ENTRIES = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_write,
   input  wire logic [0:0]             csr_index,
   input  wire logic [13:0]            csr_data,
   input  wire bsts_pkg::req_type_type req_data,
   input  wire bsts_pkg::cmd_type      cmd,
   output bsts_pkg::status_type        sts,
   output bsts_pkg::rsp_type           rsp_data
);
   localparam int unsigned AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
   localparam int unsigned CW = $clog2(MAX_ENTRIES + 1);

   logic [6:0]  entry_count_ff;
   logic [13:0] half_window_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= 7'd0;
         half_window_ff <= 14'd640;
      end else if (csr_write) begin
         if (csr_index == bsts_pkg::CSR_ENTRY_COUNT) entry_count_ff <= csr_data[6:0];
         else half_window_ff <= csr_data;
      end
   end

   logic [47:0] mem [MAX_ENTRIES];
   logic [47:0] rd_ff;
   bsts_pkg::req_type_type item_ff;
   logic [CW-1:0] scan_ff;
   logic [CW-1:0] limit;
   always_comb begin
      if (32'(entry_count_ff) > MAX_ENTRIES) limit = CW'(MAX_ENTRIES);
      else limit = CW'(entry_count_ff);
   end

   always_ff @(posedge clock) begin
      if (cmd.take_item) item_ff <= req_data;
      if (cmd.write_entry && 32'(item_ff.entry_index) < MAX_ENTRIES)
         mem[AW'(item_ff.entry_index)] <= {item_ff.pos_x, item_ff.pos_y, item_ff.pos_z};
      if (cmd.read_entry) rd_ff <= mem[scan_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (cmd.take_item) scan_ff <= '0;
      else if (cmd.next_entry) scan_ff <= scan_ff + 1'b1;
   end

   logic signed [15:0] ex_ff, ez_ff;
   logic signed [15:0] ey;
   assign ey = rd_ff[31:16];
   always_ff @(posedge clock) begin
      if (cmd.load_entry) begin
         ex_ff <= rd_ff[47:32];
         ez_ff <= rd_ff[15:0];
      end
   end

   // Square sum, then bit-pair square root, one result bit a cycle.
   // The partial root runs as wide as the trial bit until the last steps.
   logic [31:0] ysq_ff, zsq_ff;
   logic [32:0] rem_ff;
   logic [32:0] root_ff;
   logic [32:0] bit_ff;
   logic [4:0]  sq_cnt_ff;
   logic [32:0] trial;
   assign trial = root_ff + bit_ff;
   always_ff @(posedge clock) begin
      if (cmd.load_entry) begin
         ysq_ff <= 32'($signed(ey) * $signed(ey));
         zsq_ff <= 32'($signed(rd_ff[15:0]) * $signed(rd_ff[15:0]));
      end
      if (cmd.square) begin
         rem_ff <= {1'b0, ysq_ff} + {1'b0, zsq_ff};
         root_ff <= '0;
         bit_ff <= 33'h1_0000_0000;
         sq_cnt_ff <= '0;
      end else if (cmd.sqrt_step) begin
         if (rem_ff >= trial) begin
            rem_ff <= rem_ff - trial;
            root_ff <= (root_ff >> 1) + bit_ff;
         end else begin
            root_ff <= root_ff >> 1;
         end
         bit_ff <= bit_ff >> 2;
         sq_cnt_ff <= sq_cnt_ff + 1'b1;
      end
   end

   // CORDIC vectoring, one step a cycle.
   logic signed [27:0] cx_ff, cy_ff;
   logic signed [23:0] acc_ff;
   logic [4:0] it_ff;
   logic signed [27:0] sx, sy;
   assign sx = cx_ff >>> it_ff;
   assign sy = cy_ff >>> it_ff;
   always_ff @(posedge clock) begin
      if (cmd.cordic_setup) begin
         it_ff <= '0;
         if (ex_ff < 0) begin
            cx_ff <= 28'({11'd0, root_ff[16:0]} <<< 8);
            cy_ff <= 28'(-(28'(ex_ff))) <<< 8;
            acc_ff <= 24'sd1474560;
         end else begin
            cx_ff <= 28'(ex_ff) <<< 8;
            cy_ff <= 28'({11'd0, root_ff[16:0]} <<< 8);
            acc_ff <= '0;
         end
      end else if (cmd.cordic_step) begin
         it_ff <= it_ff + 1'b1;
         if (cy_ff >= 0) begin
            cx_ff <= cx_ff + sy;
            cy_ff <= cy_ff - sx;
            acc_ff <= acc_ff + $signed({2'b0, bsts_pkg::atan_entry(it_ff)});
         end else begin
            cx_ff <= cx_ff - sy;
            cy_ff <= cy_ff + sx;
            acc_ff <= acc_ff - $signed({2'b0, bsts_pkg::atan_entry(it_ff)});
         end
      end
   end

   // Bearing and window test.
   logic [23:0] acc_c;
   logic [14:0] b0, brg, q, lo, hi;
   logic [15:0] t_lo, t_hi;
   logic hit;
   always_comb begin
      if (acc_ff < 0) acc_c = '0;
      else if (acc_ff > 24'sd2949120) acc_c = 24'd2949120;
      else acc_c = acc_ff;
      b0 = 15'((acc_c + 24'd128) >> 8);
      if (ez_ff < 0 && b0 != 15'd0) brg = 15'(bsts_pkg::FULL_TURN) - b0;
      else brg = b0;
      if (item_ff.query_angle >= 15'(bsts_pkg::FULL_TURN))
         q = item_ff.query_angle - 15'(bsts_pkg::FULL_TURN);
      else q = item_ff.query_angle;
      t_lo = 16'(brg) + 16'(bsts_pkg::FULL_TURN) - 16'(half_window_ff);
      if (t_lo >= 16'(bsts_pkg::FULL_TURN)) t_lo = t_lo - 16'(bsts_pkg::FULL_TURN);
      t_hi = 16'(brg) + 16'(half_window_ff);
      if (t_hi >= 16'(bsts_pkg::FULL_TURN)) t_hi = t_hi - 16'(bsts_pkg::FULL_TURN);
      lo = t_lo[14:0];
      hi = t_hi[14:0];
      if (lo <= hi) hit = (q >= lo) && (q <= hi);
      else hit = (q >= lo) || (q <= hi);
   end

   always_ff @(posedge clock) begin
      if (cmd.take_item) begin
         rsp_data <= '0;
      end else if (cmd.set_result) begin
         rsp_data.match_found <= 1'b1;
         rsp_data.match_index <= 6'(scan_ff);
      end
   end

   always_comb begin
      sts.is_query    = item_ff.req_type == bsts_pkg::REQ_QUERY;
      sts.scan_done   = scan_ff >= limit;
      sts.entry_zero  = rd_ff == 48'd0;
      sts.wide_window = {half_window_ff, 1'b0} >= 15'(bsts_pkg::FULL_TURN);
      sts.sqrt_last   = sq_cnt_ff == 5'(bsts_pkg::SQRT_STEPS);
      sts.cordic_last = it_ff == 5'(bsts_pkg::CORDIC_STEPS - 1);
      sts.hit         = hit;
   end
endmodule
`default_nettype wire

// ===== rtl/core/bearing_sector_target_search.sv =====
// Sequence: a write stores its entry and then offers the result; a query steps through each
// scanned nonzero entry (read, load, square, 17-step root, setup, 18-step CORDIC, compare),
// reads and skips an origin entry, and with a full-turn window hits at the first nonzero entry.
// Flow: one item at a time; the next item is taken once the result is accepted.
// Reset: synchronous, active high; entry_count 0, half_window 640, table undefined.
`default_nettype none
module bearing_sector_target_search #(
   parameter int unsigned MAX_ENTRIES = 64
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire bsts_pkg::req_type_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output bsts_pkg::rsp_type           rsp_data,
   input  wire logic                   csr_write,
   input  wire logic [0:0]             csr_index,
   input  wire logic [13:0]            csr_data
);
   bsts_pkg::cmd_type    cmd;
   bsts_pkg::status_type sts;

   // Sequencer: one item in flight, result held until taken.
   bsts_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .cmd, .sts
   );

   // Table, root, CORDIC and window compare.
   // The position table is an unreset memory read one entry at a time, the next after this one is done.
   bsts_datapath #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
      .clock, .reset, .csr_write, .csr_index, .csr_data, .req_data, .cmd, .sts, .rsp_data
   );
endmodule
`default_nettype wire

// ===== rtl/core/bsts_checker.sv =====
// Port-level checker for the bearing sector target search block.
`default_nettype none
`include "bearing_sector_target_search_macros.svh"
module bsts_checker (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_ready,
   input wire logic              rsp_valid,
   input wire logic              rsp_ready,
   input wire bsts_pkg::rsp_type rsp_data
);
   `BSTS_ASSERT_IMPL(no_in_during_out, clock, reset, rsp_valid, !req_ready)
   `BSTS_ASSERT_NEXT(rsp_holds, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
   `BSTS_ASSERT_IMPL(miss_index_zero, clock, reset, rsp_valid && !rsp_data.match_found, rsp_data.match_index == 6'd0)
   `BSTS_ASSERT_NEXT(accept_busy, clock, reset, req_valid && req_ready, !req_ready)
endmodule

bind bearing_sector_target_search bsts_checker u_chk (
   .clock, .reset, .req_valid, .req_ready, .rsp_valid, .rsp_ready, .rsp_data
);
`default_nettype wire

// ===== tb/bearing_sector_target_search_test.sv =====
// Self-checking test of the bearing sector target search block.
`default_nettype none
module bearing_sector_target_search_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int TABLE_SIZE = 64;
   localparam int WATCHDOG_LIMIT = 200000;
   localparam int ATAN_TAB [bsts_pkg::CORDIC_STEPS] = '{737280, 435242, 229970, 116736,
      58595, 29326, 14667, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7};

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   bsts_pkg::req_type_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   bsts_pkg::rsp_type rsp_data;
   logic csr_write = 1'b0;
   logic [0:0] csr_index = bsts_pkg::CSR_ENTRY_COUNT;
   logic [13:0] csr_data = '0;

   bearing_sector_target_search dut (.*);

   // Shadow copy of the block's table and registers.
   logic signed [15:0] shadow_x [TABLE_SIZE];
   logic signed [15:0] shadow_y [TABLE_SIZE];
   logic signed [15:0] shadow_z [TABLE_SIZE];
   int unsigned scan_count;
   int unsigned window_half;

   bsts_pkg::rsp_type expected_matches [$];
   int error_count = 0;
   int item_count = 0;
   int query_count = 0;
   int hit_count = 0;
   int send_idle_pct = 0;
   int recv_stall_pct = 0;
   int idle_cycles = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   // Receiver stall pattern, driven on the falling edge.
   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // Result checker: oldest expectation first.
   always @(posedge clock) begin
      bsts_pkg::rsp_type exp_rsp;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_matches.size() == 0) begin
            $error("unexpected result %p", rsp_data);
            error_count++;
         end else begin
            exp_rsp = expected_matches.pop_front();
            if (rsp_data.match_found !== exp_rsp.match_found) begin
               $error("match_found expected %0d actual %0d",
                      exp_rsp.match_found, rsp_data.match_found);
               error_count++;
            end
            if (rsp_data.match_index !== exp_rsp.match_index) begin
               $error("match_index expected %0d actual %0d",
                      exp_rsp.match_index, rsp_data.match_index);
               error_count++;
            end
            if (exp_rsp.match_found) hit_count++;
         end
      end
   end

   // Watchdog: cycles with no item accepted on either channel.
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic longint floor_shift(longint v, int k);
      return v >>> k;   // longint is signed, so this floors
   endfunction

   function automatic longint int_sqrt(longint n);
      longint res, bit_val;
      res = 0;
      bit_val = 64'sd1 << 32;
      while (bit_val > n) bit_val >>= 2;
      while (bit_val != 0) begin
         if (n >= res + bit_val) begin
            n -= res + bit_val;
            res = (res >> 1) + bit_val;
         end else begin
            res >>= 1;
         end
         bit_val >>= 2;
      end
      return res;
   endfunction

   // Bearing in 1/64 degree, from root plus CORDIC vectoring.
   function automatic int target_bearing(longint x, longint y, longint z);
      longint r, cx, cy, acc, t;
      int b;
      r = int_sqrt(y * y + z * z);
      if (x < 0) begin
         cx = r * 256; cy = -x * 256; acc = 1474560;
      end else begin
         cx = x * 256; cy = r * 256; acc = 0;
      end
      for (int i = 0; i < bsts_pkg::CORDIC_STEPS; i++) begin
         t = cx;
         if (cy >= 0) begin
            cx = cx + floor_shift(cy, i); cy = cy - floor_shift(t, i); acc += ATAN_TAB[i];
         end else begin
            cx = cx - floor_shift(cy, i); cy = cy + floor_shift(t, i); acc -= ATAN_TAB[i];
         end
      end
      if (acc < 0) acc = 0;
      if (acc > 2949120) acc = 2949120;
      b = int'((acc + 128) >>> 8);
      if (z < 0) b = (bsts_pkg::FULL_TURN - b) % bsts_pkg::FULL_TURN;
      return b;
   endfunction

   // Expected result of one item; writes update the shadow table.
   function automatic bsts_pkg::rsp_type predict_match(bsts_pkg::req_type_type item);
      bsts_pkg::rsp_type res;
      int unsigned q, n, b, lo, hi;
      bit hit;
      res = '0;
      if (item.req_type == bsts_pkg::REQ_WRITE) begin
         shadow_x[item.entry_index] = item.pos_x;
         shadow_y[item.entry_index] = item.pos_y;
         shadow_z[item.entry_index] = item.pos_z;
         return res;
      end
      q = item.query_angle;
      if (q >= bsts_pkg::FULL_TURN) q -= bsts_pkg::FULL_TURN;
      n = (scan_count > TABLE_SIZE) ? TABLE_SIZE : scan_count;
      for (int i = 0; i < n; i++) begin
         if (shadow_x[i] == 0 && shadow_y[i] == 0 && shadow_z[i] == 0) continue;
         if (2 * window_half >= bsts_pkg::FULL_TURN) begin
            hit = 1'b1;
         end else begin
            b = target_bearing(shadow_x[i], shadow_y[i], shadow_z[i]);
            lo = (b + bsts_pkg::FULL_TURN - window_half) % bsts_pkg::FULL_TURN;
            hi = (b + window_half) % bsts_pkg::FULL_TURN;
            hit = (lo <= hi) ? (q >= lo && q <= hi) : (q >= lo || q <= hi);
         end
         if (hit) begin
            res.match_found = 1'b1;
            res.match_index = i[5:0];
            return res;
         end
      end
      return res;
   endfunction

   // Send one item; queued prediction at acceptance order.
   // Returns at the falling edge after acceptance with valid still high.
   task automatic send_item(bsts_pkg::req_type_type item);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      if (item.req_type == bsts_pkg::REQ_QUERY) query_count++;
      expected_matches.push_back(predict_match(item));
      req_data <= item;
      req_valid <= 1'b1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      item_count++;
      @(negedge clock);
   endtask

   // Block must be idle before a register write: wait for results plus slack.
   task automatic drain_block();
      req_valid <= 1'b0;
      while (expected_matches.size() != 0) @(negedge clock);
      repeat (10) @(negedge clock);
   endtask

   task automatic write_csr(logic [0:0] idx, int unsigned value);
      drain_block();
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data <= value[13:0];
      if (idx == bsts_pkg::CSR_ENTRY_COUNT) scan_count = value & 'h7F;
      else window_half = value & 'h3FFF;
      @(negedge clock);
      csr_write <= 1'b0;
   endtask

   function automatic bsts_pkg::req_type_type make_write(int idx, int x, int y, int z);
      bsts_pkg::req_type_type it;
      it = '0;
      it.req_type = bsts_pkg::REQ_WRITE;
      it.entry_index = idx[5:0];
      it.pos_x = x[15:0]; it.pos_y = y[15:0]; it.pos_z = z[15:0];
      it.query_angle = 15'($urandom);
      return it;
   endfunction

   function automatic bsts_pkg::req_type_type make_query(int angle);
      bsts_pkg::req_type_type it;
      logic [95:0] raw;
      raw = {$urandom, $urandom, $urandom};
      it = raw[$bits(bsts_pkg::req_type_type)-1:0];
      it.req_type = bsts_pkg::REQ_QUERY;
      it.query_angle = angle[14:0];
      return it;
   endfunction

   // Random coordinate: mostly full range, some extremes and small values.
   function automatic int rand_coord();
      case ($urandom_range(5))
         0: return -32768;
         1: return 32767;
         2: return int'($urandom_range(8)) - 4;
         default: return int'($urandom_range(65535)) - 32768;
      endcase
   endfunction

   // Fill the whole table so no later query scans an unwritten entry.
   task automatic test_fill_table();
      for (int i = 0; i < TABLE_SIZE; i++)
         send_item(make_write(i, rand_coord(), rand_coord(), rand_coord()));
   endtask

   // Directed: axes, extremes, origin skip, wraps, out-of-range angle.
   task automatic test_directed();
      write_csr(bsts_pkg::CSR_ENTRY_COUNT, 0);
      send_item(make_query(0));                   // nothing scanned
      send_item(make_write(0, 0, 0, 0));          // origin target
      send_item(make_write(1, 1000, 0, 0));       // bearing 0
      send_item(make_write(2, -32768, 0, 0));     // bearing 180
      send_item(make_write(3, 0, 0, -32768));     // bearing 270
      send_item(make_write(4, 32767, 32767, 32767));
      send_item(make_write(5, -32768, -32768, -32768));
      write_csr(bsts_pkg::CSR_ENTRY_COUNT, 6);
      send_item(make_query(0));
      send_item(make_query(23039));               // lower wrap
      send_item(make_query(640));
      send_item(make_query(11520));
      send_item(make_query(17280));
      send_item(make_query(32767));               // reduced by a full turn
      send_item(make_query(23040 + 600));
      write_csr(bsts_pkg::CSR_HALF_WINDOW, 0);
      send_item(make_query(0));
      send_item(make_query(11520));
      write_csr(bsts_pkg::CSR_HALF_WINDOW, 11520);          // whole turn
      send_item(make_query(5000));
      write_csr(bsts_pkg::CSR_HALF_WINDOW, 16383);
      write_csr(bsts_pkg::CSR_ENTRY_COUNT, 127);            // saturates
      send_item(make_query(100));
      write_csr(bsts_pkg::CSR_HALF_WINDOW, 11519);
      send_item(make_query(12000));
   endtask

   // Random phase with one register setting and one idling mix.
   task automatic test_random_phase(int n, int idle_pct, int stall_pct);
      bsts_pkg::req_type_type it;
      send_idle_pct = idle_pct;
      recv_stall_pct = stall_pct;
      case ($urandom_range(3))
         0: write_csr(bsts_pkg::CSR_ENTRY_COUNT, $urandom_range(8, 1));
         1: write_csr(bsts_pkg::CSR_ENTRY_COUNT, 64);
         default: write_csr(bsts_pkg::CSR_ENTRY_COUNT, $urandom_range(127));
      endcase
      write_csr(bsts_pkg::CSR_HALF_WINDOW, ($urandom_range(3) == 0) ?
                $urandom_range(16383) : $urandom_range(2000));
      for (int k = 0; k < n; k++) begin
         if ($urandom_range(2) == 0)
            it = make_write($urandom_range(63), rand_coord(), rand_coord(), rand_coord());
         else
            it = make_query($urandom_range(32767));
         send_item(it);
      end
   endtask

   initial begin
      for (int i = 0; i < TABLE_SIZE; i++) begin
         shadow_x[i] = 0; shadow_y[i] = 0; shadow_z[i] = 0;
      end
      scan_count = 0;
      window_half = 640;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      test_directed();
      test_fill_table();
      // Queries are slow at large counts, so the phases stay moderate.
      for (int p = 0; p < 16; p++) begin
         case (p % 4)
            0: test_random_phase(120, 0, 0);
            1: test_random_phase(120, 53, 0);
            2: test_random_phase(120, 0, 53);
            default: test_random_phase(120, 25, 25);
         endcase
      end
      drain_block();
      repeat (50) @(negedge clock);
      $display("tb: %0d items sent, %0d queries, %0d hits, %0d mismatches",
               item_count, query_count, hit_count, error_count);
      if (error_count == 0 && expected_matches.size() == 0)
         $display("tb: success");
      else
         $display("tb: failure");
      $finish;
   end
endmodule
`default_nettype wire

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/bsts_pkg.sv
rtl/core/bsts_ctrl.sv
rtl/core/bsts_datapath.sv
rtl/core/bearing_sector_target_search.sv
rtl/core/bsts_checker.sv
tb/bearing_sector_target_search_test.sv
